[rtl/go_back_n_sender_window_assert.svh]
// Assertion macros for the Go-Back-N sender window.
// Clocked on clk, disabled while arst_n is low; NO_ASSERTIONS compiles them out.
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define GBN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define GBN_ASSERT_IMP(lbl, ante, cons)
`define GBN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/gbn_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, codes and reset values for the Go-Back-N sender window.
// No dependencies.
package gbn_pkg;
	localparam int MAX_WINDOW = 8;
	localparam int PAY_W      = 32;
	localparam int SEQ_W      = 16;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int SB_W       = 5;
	localparam int CFG_W      = 5;
	localparam int CIDX_W     = 2;
	localparam int ACT_W      = 2;
	localparam int TMR_W      = 2;
	localparam int MCNT_W     = $clog2(SEQ_W);

	localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TOUT  = 2'd2;

	localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
	localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
	localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
	localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

	localparam logic [CIDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SEQ    = 2'd1;

	localparam logic [WIN_W-1:0] WINDOW_RST = 4'd4;
	localparam logic [SB_W-1:0]  SEQ_RST    = 5'd3;
endpackage

[rtl/gbn_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/go_back_n_sender_window.sv]
`timescale 1ns / 1ps
// Go-Back-N sender window: send, ACK and timeout items against a payload RAM.
// Results are registered and appear in the cycle after the item is taken. An intact
// ACK also runs the bit-serial sequence-mod-window unit while busy. Timeout: one
// resent packet per cycle from the RAM read port. A config write passes through
// write, mask and the mod unit. Async reset restores window 4, seq_bits 3, base
// and next 0; the receiver cannot stall.
`include "go_back_n_sender_window_assert.svh"
module go_back_n_sender_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [gbn_pkg::ACT_W-1:0]   action,
	input  logic [gbn_pkg::PAY_W-1:0]   payload,
	input  logic [gbn_pkg::SEQ_W-1:0]   ack_num,
	input  logic                        ack_intact,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gbn_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [gbn_pkg::CFG_W-1:0]   cfg_data,
	output logic                        done,
	output logic                        accepted,
	output logic                        pkt_valid,
	output logic [gbn_pkg::SEQ_W-1:0]   pkt_seq,
	output logic [gbn_pkg::PAY_W-1:0]   pkt_payload,
	output logic [gbn_pkg::TMR_W-1:0]   timer_action,
	output logic [gbn_pkg::SEQ_W-1:0]   window_base,
	output logic                        last
);
	import gbn_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TX   = 4'b0010,
		ST_CFG  = 4'b0100,
		ST_MOD  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [WIN_W-1:0]    window_q;
	logic [SB_W-1:0]     seq_bits_q;
	logic [SEQ_W-1:0]    base_q, next_q, cur_seq_q;
	logic [IDX_W-1:0]    base_idx_q, next_idx_q, cur_idx_q;
	logic [WIN_W-1:0]    left_q;
	logic [SEQ_W-1:0]    sh_a_q, sh_b_q;
	logic [IDX_W-1:0]    rem_a_q, rem_b_q;
	logic [MCNT_W-1:0]   mcnt_q;

	logic                done_s1, acc_s1, pv_s1, last_s1, from_ram_s1;
	logic [SEQ_W-1:0]    seq_s1, wbase_s1;
	logic [PAY_W-1:0]    pay_s1;
	logic [TMR_W-1:0]    tmr_s1;

	logic [SB_W-1:0]     sb_eff;
	logic [SEQ_W-1:0]    smask;
	logic [WIN_W-1:0]    w_lim, w_eff;
	logic                take, full, tx_fin;
	logic [SEQ_W-1:0]    diff, ack_base;
	logic [WIN_W-1:0]    tx_cnt;
	logic [WIN_W-1:0]    t_a, t_b;
	logic [IDX_W-1:0]    rem_a_n, rem_b_n;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_raddr;
	logic [PAY_W-1:0]    ram_rdata;

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s,
		input logic [SEQ_W-1:0] m);
		return (s + 1'b1) & m;
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [SEQ_W-1:0] s,
		input logic [IDX_W-1:0] i, input logic [SEQ_W-1:0] m, input logic [WIN_W-1:0] w);
		if (s == m) begin
			return '0;
		end
		if (WIN_W'(i) + WIN_W'(1) == w) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	always_comb begin
		sb_eff = (seq_bits_q == '0 || seq_bits_q > SB_W'(SEQ_W)) ? SB_W'(SEQ_W) : seq_bits_q;
		smask  = ~({SEQ_W{1'b1}} << sb_eff);
		w_lim  = (window_q == '0) ? WIN_W'(1) :
			(window_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_q;
		w_eff  = (SEQ_W'(w_lim) > smask) ? smask[WIN_W-1:0] : w_lim;
	end

	assign busy      = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign take      = start && !busy;
	assign full      = next_q == ((base_q + SEQ_W'(w_eff)) & smask);
	assign diff      = (next_q - base_q) & smask;
	assign tx_cnt    = (diff > SEQ_W'(w_eff)) ? w_eff : diff[WIN_W-1:0];
	assign ack_base  = (ack_num + 1'b1) & smask;
	assign tx_fin    = (left_q == WIN_W'(1));

	// bit-serial remainder, MSB first; remainder stays below the window
	assign t_a     = WIN_W'({rem_a_q, sh_a_q[SEQ_W-1]});
	assign t_b     = WIN_W'({rem_b_q, sh_b_q[SEQ_W-1]});
	assign rem_a_n = (t_a >= w_eff) ? IDX_W'(t_a - w_eff) : t_a[IDX_W-1:0];
	assign rem_b_n = (t_b >= w_eff) ? IDX_W'(t_b - w_eff) : t_b[IDX_W-1:0];

	assign ram_we    = take && (action == ACT_SEND) && !full;
	assign ram_raddr = (state_q == ST_TX) ? cur_idx_q : base_idx_q;

	gbn_ram #(
		.WIDTH (PAY_W),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (next_idx_q),
		.wdata (payload),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= WINDOW_RST;
			seq_bits_q <= SEQ_RST;
			base_q     <= '0;
			next_q     <= '0;
			base_idx_q <= '0;
			next_idx_q <= '0;
			cur_seq_q  <= '0;
			cur_idx_q  <= '0;
			left_q     <= '0;
			sh_a_q     <= '0;
			sh_b_q     <= '0;
			rem_a_q    <= '0;
			rem_b_q    <= '0;
			mcnt_q     <= '0;
			done_s1    <= 1'b0;
		end else begin
			done_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_WINDOW) begin
							window_q <= cfg_data[WIN_W-1:0];
						end else if (cfg_index == REG_SEQ) begin
							seq_bits_q <= cfg_data[SB_W-1:0];
						end
						state_q <= ST_CFG;
					end else if (start) begin
						done_s1 <= 1'b1;
						case (action)
							ACT_SEND: begin
								if (!full) begin
									next_q     <= seq_inc(next_q, smask);
									next_idx_q <= idx_inc(next_q, next_idx_q, smask, w_eff);
								end
							end
							ACT_ACK: begin
								if (ack_intact) begin
									base_q  <= ack_base;
									sh_a_q  <= ack_base;
									sh_b_q  <= next_q;
									rem_a_q <= '0;
									rem_b_q <= '0;
									mcnt_q  <= '0;
									state_q <= ST_MOD;
								end
							end
							ACT_TOUT: begin
								if (tx_cnt > WIN_W'(1)) begin
									cur_seq_q <= seq_inc(base_q, smask);
									cur_idx_q <= idx_inc(base_q, base_idx_q, smask, w_eff);
									left_q    <= tx_cnt - WIN_W'(1);
									state_q   <= ST_TX;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_TX: begin
					done_s1   <= 1'b1;
					cur_seq_q <= seq_inc(cur_seq_q, smask);
					cur_idx_q <= idx_inc(cur_seq_q, cur_idx_q, smask, w_eff);
					left_q    <= left_q - WIN_W'(1);
					if (tx_fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CFG: begin
					base_q  <= base_q & smask;
					next_q  <= next_q & smask;
					sh_a_q  <= base_q & smask;
					sh_b_q  <= next_q & smask;
					rem_a_q <= '0;
					rem_b_q <= '0;
					mcnt_q  <= '0;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					sh_a_q  <= sh_a_q << 1;
					sh_b_q  <= sh_b_q << 1;
					rem_a_q <= rem_a_n;
					rem_b_q <= rem_b_n;
					mcnt_q  <= mcnt_q + 1'b1;
					if (mcnt_q == MCNT_W'(SEQ_W - 1)) begin
						base_idx_q <= rem_a_n;
						next_idx_q <= rem_b_n;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result fields; loaded whenever a result is produced
	always_ff @(posedge clk) begin
		if (state_q == ST_TX) begin
			acc_s1      <= 1'b0;
			pv_s1       <= 1'b1;
			seq_s1      <= cur_seq_q;
			pay_s1      <= '0;
			from_ram_s1 <= 1'b1;
			tmr_s1      <= tx_fin ? TMR_RESTART : TMR_NONE;
			last_s1     <= tx_fin;
			wbase_s1    <= base_q;
		end else if (take) begin
			acc_s1      <= 1'b0;
			pv_s1       <= 1'b0;
			seq_s1      <= '0;
			pay_s1      <= '0;
			from_ram_s1 <= 1'b0;
			tmr_s1      <= TMR_NONE;
			last_s1     <= 1'b1;
			wbase_s1    <= base_q;
			case (action)
				ACT_SEND: begin
					if (!full) begin
						acc_s1 <= 1'b1;
						pv_s1  <= 1'b1;
						seq_s1 <= next_q;
						pay_s1 <= payload;
						tmr_s1 <= (base_q == next_q) ? TMR_START : TMR_NONE;
					end
				end
				ACT_ACK: begin
					if (ack_intact) begin
						tmr_s1   <= (ack_base != next_q) ? TMR_RESTART : TMR_STOP;
						wbase_s1 <= ack_base;
					end
				end
				ACT_TOUT: begin
					if (tx_cnt == '0) begin
						tmr_s1 <= TMR_RESTART;
					end else begin
						pv_s1       <= 1'b1;
						seq_s1      <= base_q;
						from_ram_s1 <= 1'b1;
						tmr_s1      <= (tx_cnt == WIN_W'(1)) ? TMR_RESTART : TMR_NONE;
						last_s1     <= (tx_cnt == WIN_W'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done         = done_s1;
	assign accepted     = acc_s1;
	assign pkt_valid    = pv_s1;
	assign pkt_seq      = seq_s1;
	assign pkt_payload  = from_ram_s1 ? ram_rdata : pay_s1;
	assign timer_action = tmr_s1;
	assign window_base  = wbase_s1;
	assign last         = last_s1;

	`GBN_ASSERT_IMP(a_seq_masked, state_q == ST_IDLE, ((base_q & ~smask) == '0) && ((next_q & ~smask) == '0))
	`GBN_ASSERT_IMP(a_idx_in_window, state_q == ST_IDLE, (WIN_W'(base_idx_q) < w_eff) && (WIN_W'(next_idx_q) < w_eff))
	`GBN_ASSERT_NXT(a_item_answered, start && !busy, done)
	`GBN_ASSERT_NXT(a_resend_burst, done && !last, done && pkt_valid)
endmodule
